FILE: hw/rtl/b64sc_pkg.sv
// shared types, codes and character helpers of the base64 stream codec
// no dependencies; imported by every codec module
`default_nettype none

package b64sc_pkg;

   // request kinds
   typedef enum logic [2:0] {
      KIND_DEC_CHAR = 3'd0,
      KIND_DEC_END  = 3'd1,
      KIND_ENC_BYTE = 3'd2,
      KIND_ENC_FIN  = 3'd3,
      KIND_RESTART  = 3'd4
   } kind_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_DATA = 2'd0,
      STAT_NEXT = 2'd1,
      STAT_ERR  = 2'd2,
      STAT_END  = 2'd3
   } status_type;

   // shared codec mode
   typedef enum logic [3:0] {
      ST_START = 4'd0,
      ST_DA    = 4'd1,
      ST_DB    = 4'd2,
      ST_DC    = 4'd3,
      ST_DD    = 4'd4,
      ST_PAD3  = 4'd5,
      ST_PAD2  = 4'd6,
      ST_PAD1  = 4'd7,
      ST_END   = 4'd8,
      ST_EA    = 4'd10,
      ST_EB    = 4'd11,
      ST_EC    = 4'd12
   } mode_type;

   localparam logic [7:0] PAD_RESET = 8'd61;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] in_char;
      logic       final_req;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic       last;
   } rsp_type;

   // one accepted item's results, handed from front to back
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      status_type      status;
   } desc_type;

   // queue status toward front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // alphabet value of a character; bit 6 set when not in the alphabet
   function automatic logic [6:0] char_value(input logic [7:0] c);
      logic [6:0] v;
      v = 7'h40;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = {1'b0, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2b) begin
         v = 7'd62;
      end else if (c == 8'h2f) begin
         v = 7'd63;
      end
      return v;
   endfunction

   // alphabet character of a 6-bit value
   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2b;
      end else begin
         c = 8'h2f;
      end
      return c;
   endfunction

   // punctuation accepted as pad character
   function automatic logic pad_allowed(input logic [7:0] c);
      logic ok;
      unique case (c)
         8'h22, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h2c, 8'h2d,
         8'h2e, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h5f: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b64sc_front.sv
// front end: accepts requests, keeps mode, hold bits and pad character,
// and builds the result list of each item; depends on b64sc_pkg
`default_nettype none

module b64sc_front import b64sc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   input  wire req_type    req_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_wdata,
   input  wire q_stat_type q_stat,
   output logic            q_push,
   output desc_type        q_data
);

   mode_type   state_ff, state_in;
   logic [5:0] hold_ff, hold_in;
   logic [7:0] pad_ff;

   logic       accept;
   logic [7:0] dec_char;
   logic       is_pad;
   logic [6:0] cval;
   logic [5:0] val;
   logic [7:0] b;
   logic [5:0] hold_a, hold_b;
   logic [7:0] e_a, e_b, e_c1, e_c2, e_ta, e_tb, e_th;
   logic [2:0] cnt;
   logic [3:0][7:0] bytes;
   status_type status;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !q_stat.full;

   // character classification
   assign dec_char = (req_data.kind == KIND_DEC_END) ? pad_ff : req_data.in_char;
   assign is_pad   = (dec_char == pad_ff);
   assign cval     = char_value(dec_char);
   assign val      = cval[5:0];

   // encode candidates
   assign b      = req_data.in_char;
   assign hold_a = {b[1:0], 4'b0000};
   assign hold_b = {b[3:0], 2'b00};
   assign e_a    = enc_char(b[7:2]);
   assign e_b    = enc_char(hold_ff | {2'b00, b[7:4]});
   assign e_c1   = enc_char(hold_ff | {4'b0000, b[7:6]});
   assign e_c2   = enc_char(b[5:0]);
   assign e_ta   = enc_char(hold_a);
   assign e_tb   = enc_char(hold_b);
   assign e_th   = enc_char(hold_ff);

   // next mode and result list
   always_comb begin
      state_in = state_ff;
      hold_in  = hold_ff;
      cnt      = 3'd0;
      bytes    = '0;
      status   = STAT_DATA;
      unique case (req_data.kind)
         KIND_DEC_CHAR, KIND_DEC_END: begin
            cnt = 3'd1;
            if (!is_pad && cval[6]) begin
               status = STAT_NEXT;
            end else begin
               unique case (state_ff)
                  ST_START, ST_DA: begin
                     status = STAT_NEXT;
                     if (is_pad) begin
                        state_in = ST_PAD3;
                     end else begin
                        hold_in  = val;
                        state_in = ST_DB;
                     end
                  end
                  ST_DB: begin
                     if (is_pad) begin
                        status = STAT_ERR;
                     end else begin
                        bytes[0] = {hold_ff, val[5:4]};
                        hold_in  = val;
                        state_in = ST_DC;
                     end
                  end
                  ST_DC: begin
                     if (is_pad) begin
                        status   = STAT_NEXT;
                        state_in = ST_PAD1;
                     end else begin
                        bytes[0] = {hold_ff[3:0], val[5:2]};
                        hold_in  = val;
                        state_in = ST_DD;
                     end
                  end
                  ST_DD: begin
                     if (is_pad) begin
                        status   = STAT_END;
                        state_in = ST_END;
                     end else begin
                        bytes[0] = {hold_ff[1:0], val};
                        state_in = ST_DA;
                     end
                  end
                  ST_PAD3, ST_PAD2: begin
                     if (!is_pad) begin
                        status = STAT_ERR;
                     end else begin
                        status   = STAT_NEXT;
                        state_in = (state_ff == ST_PAD3) ? ST_PAD2 : ST_PAD1;
                     end
                  end
                  ST_PAD1: begin
                     if (!is_pad) begin
                        status = STAT_ERR;
                     end else begin
                        status   = STAT_END;
                        state_in = ST_END;
                     end
                  end
                  ST_END: begin
                     status = STAT_END;
                  end
                  default: begin
                     status = STAT_ERR;
                  end
               endcase
            end
         end
         KIND_ENC_BYTE: begin
            unique case (state_ff)
               ST_START, ST_EA: begin
                  bytes[0] = e_a;
                  hold_in  = hold_a;
                  if (req_data.final_req) begin
                     bytes[1] = e_ta;
                     bytes[2] = pad_ff;
                     bytes[3] = pad_ff;
                     cnt      = 3'd4;
                     state_in = ST_EA;
                  end else begin
                     cnt      = 3'd1;
                     state_in = ST_EB;
                  end
               end
               ST_EB: begin
                  bytes[0] = e_b;
                  hold_in  = hold_b;
                  if (req_data.final_req) begin
                     bytes[1] = e_tb;
                     bytes[2] = pad_ff;
                     cnt      = 3'd3;
                     state_in = ST_EA;
                  end else begin
                     cnt      = 3'd1;
                     state_in = ST_EC;
                  end
               end
               ST_EC: begin
                  bytes[0] = e_c1;
                  bytes[1] = e_c2;
                  cnt      = 3'd2;
                  state_in = ST_EA;
               end
               default: begin
                  if (req_data.final_req) begin
                     state_in = ST_EA;
                  end
               end
            endcase
         end
         KIND_ENC_FIN: begin
            state_in = ST_EA;
            unique case (state_ff)
               ST_START, ST_EA: begin
                  bytes = {4{pad_ff}};
                  cnt   = 3'd4;
               end
               ST_EB: begin
                  bytes[0] = e_th;
                  bytes[1] = pad_ff;
                  bytes[2] = pad_ff;
                  cnt      = 3'd3;
               end
               ST_EC: begin
                  bytes[0] = e_th;
                  bytes[1] = pad_ff;
                  cnt      = 3'd2;
               end
               default: begin
                  cnt = 3'd0;
               end
            endcase
         end
         KIND_RESTART: begin
            state_in = ST_START;
            hold_in  = '0;
         end
         default: begin
            cnt = 3'd0;
         end
      endcase
   end

   // handoff to the queue
   assign q_push          = accept && (cnt != 3'd0);
   assign q_data.bytes    = bytes;
   assign q_data.last_idx = 2'(cnt - 3'd1);
   assign q_data.status   = status;

   // mode, hold and pad registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         hold_ff  <= '0;
         pad_ff   <= PAD_RESET;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            hold_ff  <= hold_in;
         end
         if (csr_valid && pad_allowed(csr_wdata)) begin
            pad_ff <= csr_wdata;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/b64sc_queue.sv
// small descriptor queue between front and back of the codec
// depends on b64sc_pkg
`default_nettype none

module b64sc_queue import b64sc_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_data,
   input  wire logic     pop,
   output desc_type      head,
   output q_stat_type    stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   desc_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/b64sc_back.sv
// back end: walks the head descriptor one result per cycle into the
// response register while empty or popped; depends on b64sc_pkg
`default_nettype none

module b64sc_back import b64sc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire desc_type   head,
   input  wire q_stat_type q_stat,
   output logic            q_pop,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output rsp_type         rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       at_last;

   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;
   assign load      = !q_stat.empty && (!valid_ff || rsp_pop);
   assign at_last   = (idx_ff == head.last_idx);
   assign q_pop     = load && at_last;

   // next response and walk position
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_pop;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in        = 1'b1;
         rsp_in.out_byte = head.bytes[idx_ff];
         rsp_in.status   = head.status;
         rsp_in.last     = at_last;
         idx_in          = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/base64_stream_codec.sv
// top level of the base64 stream codec: front, descriptor queue, back
// depends on b64sc_pkg, b64sc_front, b64sc_queue, b64sc_back
//
// Requests enter through a queue-like port: an item transfers when req_push
// is high and req_full is low. Each item is a decode character, a decode end,
// an encode byte (optionally final), an encode finish or a restart. The front
// end updates the shared mode and hold bits in the cycle of the transfer and
// writes the item's results (none to four) into a QUEUE_DEPTH-entry queue.
// The back end moves one result per cycle into the response register while it
// is empty or popped; the oldest result is shown while rsp_empty is low and
// transfers when rsp_pop is high. With the queue and response register idle,
// the first result passes through a queue entry, then the response register.
// Throughput: one request per cycle into the queue while req_full is low; the
// back end drains one result per cycle while the consumer keeps up. Encode
// bytes give up to two results, up to four with the final flag; finish up to four.
// When the consumer stalls, the response register holds, the queue fills and
// req_full rises. The pad character is written through csr_valid/csr_wdata
// (always ready); only allowed punctuation takes effect. Reset is synchronous:
// mode and hold clear, pad returns to '=', the queue and response register empty.
`default_nettype none

module base64_stream_codec import b64sc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire req_type    req_data,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_wdata
);

   q_stat_type q_stat;
   logic       q_push, q_pop;
   desc_type   q_in, q_head;

   assign req_full = q_stat.full;

   b64sc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   b64sc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   b64sc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a multi-result item keeps the response register filled after a transfer
   a_multi_result_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_data.last) |=> !rsp_empty)
      else $error("response register drained in the middle of an item");

   // decode status results stand alone and carry no byte
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != STAT_DATA) |->
      (rsp_data.last && rsp_data.out_byte == 8'd0))
      else $error("non-data result is not a lone zero result");

   // reset leaves both sides idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("codec not idle after reset");
`endif

endmodule

`default_nettype wire
